[hw/rtl/int32_to_float32_convert_core_defines.svh]
// Assertion macros for the int32 to float32 converter checks.
`ifndef INT32_TO_FLOAT32_CONVERT_CORE_DEFINES_SVH
`define INT32_TO_FLOAT32_CONVERT_CORE_DEFINES_SVH

// Checked only outside reset.
`define I2F_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define I2F_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/i2f_pkg.sv]
// Shared types, constants and functions of the int32 to float32 converter.
`default_nettype none

package i2f_pkg;

    localparam int unsigned IntW  = 32;
    localparam int unsigned ExpW  = 8;
    localparam int unsigned FracW = 23;
    localparam int unsigned LzW   = 5;

    localparam logic [ExpW-1:0] ExpBase = 8'd158;

    typedef struct packed {
        logic            sign;
        logic            zero;
        logic [IntW-1:0] mag;
    } i2f_mag_t;

    typedef struct packed {
        logic            sign;
        logic            zero;
        logic [LzW-1:0]  lz;
        logic [IntW-1:0] mag;
    } i2f_lzc_t;

    typedef struct packed {
        logic            sign;
        logic            zero;
        logic [LzW-1:0]  lz;
        logic [IntW-1:0] norm;
    } i2f_norm_t;

    // Leading-zero count, binary search; meaningful for nonzero input.
    function automatic logic [LzW-1:0] lzc32(input logic [IntW-1:0] x);
        logic [IntW-1:0] v;
        logic [LzW-1:0]  n;
        v = x;
        n = '0;
        if (v[31:16] == 16'd0)
        begin
            n[4] = 1'b1;
            v = {v[15:0], 16'd0};
        end
        if (v[31:24] == 8'd0)
        begin
            n[3] = 1'b1;
            v = {v[23:0], 8'd0};
        end
        if (v[31:28] == 4'd0)
        begin
            n[2] = 1'b1;
            v = {v[27:0], 4'd0};
        end
        if (v[31:30] == 2'd0)
        begin
            n[1] = 1'b1;
            v = {v[29:0], 2'd0};
        end
        if (v[31] == 1'b0)
        begin
            n[0] = 1'b1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/i2f_mag_stage.sv]
// Stage 1: sign, zero flag and absolute value of the input.
`default_nettype none

module i2f_mag_stage
    import i2f_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              valid_in,
    output logic                   ready_out,
    input  wire logic [IntW-1:0]   data_in,
    output logic                   valid_out,
    input  wire logic              ready_in,
    output i2f_mag_t               data_out
);

    logic     valid_reg;
    i2f_mag_t data_reg;
    i2f_mag_t data_next;

    assign ready_out = !valid_reg || ready_in;

    always_comb
    begin
        data_next.sign = data_in[IntW-1];
        data_next.zero = (data_in == '0);
        data_next.mag  = data_in[IntW-1] ? (IntW'(0) - data_in) : data_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_out)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

[hw/rtl/i2f_lzc_stage.sv]
// Stage 2: leading-zero count of the magnitude.
`default_nettype none

module i2f_lzc_stage
    import i2f_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     valid_in,
    output logic          ready_out,
    input  wire i2f_mag_t data_in,
    output logic          valid_out,
    input  wire logic     ready_in,
    output i2f_lzc_t      data_out
);

    logic     valid_reg;
    i2f_lzc_t data_reg;
    i2f_lzc_t data_next;

    assign ready_out = !valid_reg || ready_in;

    always_comb
    begin
        data_next.sign = data_in.sign;
        data_next.zero = data_in.zero;
        data_next.lz   = lzc32(data_in.mag);
        data_next.mag  = data_in.mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_out)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

[hw/rtl/i2f_norm_stage.sv]
// Stage 3: left shift that puts the top one bit at bit 31.
`default_nettype none

module i2f_norm_stage
    import i2f_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     valid_in,
    output logic          ready_out,
    input  wire i2f_lzc_t data_in,
    output logic          valid_out,
    input  wire logic     ready_in,
    output i2f_norm_t     data_out
);

    logic      valid_reg;
    i2f_norm_t data_reg;
    i2f_norm_t data_next;

    assign ready_out = !valid_reg || ready_in;

    always_comb
    begin
        data_next.sign = data_in.sign;
        data_next.zero = data_in.zero;
        data_next.lz   = data_in.lz;
        data_next.norm = data_in.mag << data_in.lz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_out)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

[hw/rtl/i2f_round_stage.sv]
// Stage 4: round to nearest even, exponent fix-up and packing.
`default_nettype none

module i2f_round_stage
    import i2f_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      valid_in,
    output logic           ready_out,
    input  wire i2f_norm_t data_in,
    output logic           valid_out,
    input  wire logic      ready_in,
    output logic [IntW-1:0] data_out
);

    logic              valid_reg;
    logic [IntW-1:0]   data_reg;
    logic [IntW-1:0]   data_next;
    logic              guard;
    logic              sticky;
    logic              round_up;
    logic [FracW+1:0]  sig_rnd;
    logic              carry;
    logic [ExpW-1:0]   expo;
    logic [FracW-1:0]  frac;

    assign ready_out = !valid_reg || ready_in;

    always_comb
    begin
        guard    = data_in.norm[7];
        sticky   = |data_in.norm[6:0];
        round_up = guard && (sticky || data_in.norm[8]);
        sig_rnd  = {1'b0, data_in.norm[IntW-1:8]} + (FracW+2)'(round_up);
        carry    = sig_rnd[FracW+1];
        expo     = ExpBase - ExpW'(data_in.lz) + ExpW'(carry);
        frac     = carry ? '0 : sig_rnd[FracW-1:0];
        if (data_in.zero)
        begin
            data_next = '0;
        end
        else
        begin
            data_next = {data_in.sign, expo, frac};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_out)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

[hw/rtl/int32_to_float32_convert_core.sv]
// Converts a signed 32-bit integer to an IEEE 754 single-precision bit pattern,
// rounding to nearest with ties to even. Four register stages (magnitude,
// leading-zero count, normalize shift, round and pack) lie between input beat
// and output beat and sustain one beat per cycle while out_ready is high. Each
// stage holds its beat while the next one is full and stalled, so in_ready is
// low only when all four stages hold a beat and out_ready is low.
`default_nettype none

module int32_to_float32_convert_core
    import i2f_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [IntW-1:0]   int_value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [IntW-1:0]        float_bits
);

    logic      s1_valid;
    logic      s1_ready;
    i2f_mag_t  s1_data;
    logic      s2_valid;
    logic      s2_ready;
    i2f_lzc_t  s2_data;
    logic      s3_valid;
    logic      s3_ready;
    i2f_norm_t s3_data;

    i2f_mag_stage u_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (in_valid),
        .ready_out (in_ready),
        .data_in   (int_value),
        .valid_out (s1_valid),
        .ready_in  (s1_ready),
        .data_out  (s1_data)
    );

    i2f_lzc_stage u_lzc (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s1_valid),
        .ready_out (s1_ready),
        .data_in   (s1_data),
        .valid_out (s2_valid),
        .ready_in  (s2_ready),
        .data_out  (s2_data)
    );

    i2f_norm_stage u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s2_valid),
        .ready_out (s2_ready),
        .data_in   (s2_data),
        .valid_out (s3_valid),
        .ready_in  (s3_ready),
        .data_out  (s3_data)
    );

    i2f_round_stage u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s3_valid),
        .ready_out (s3_ready),
        .data_in   (s3_data),
        .valid_out (out_valid),
        .ready_in  (out_ready),
        .data_out  (float_bits)
    );

endmodule

`default_nettype wire

[hw/rtl/i2f_checker.sv]
// Port-level checks of the converter and their bind to the top level.
`default_nettype none
`include "int32_to_float32_convert_core_defines.svh"

module i2f_checker
    import i2f_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_ready,
    input  wire logic [IntW-1:0] int_value,
    input  wire logic            out_valid,
    input  wire logic            out_ready,
    input  wire logic [IntW-1:0] float_bits
);

    `I2F_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !out_valid, "out_valid high in reset")
    `I2F_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(float_bits), "output beat changed while stalled")
    `I2F_ASSERT(a_no_neg_zero, out_valid && (float_bits[30:0] == '0) |-> !float_bits[31], "negative zero produced")
    `I2F_ASSERT(a_exp_range, out_valid && (float_bits != '0) |-> (float_bits[30:23] >= 8'd127) && (float_bits[30:23] <= 8'd158), "exponent out of integer range")
    `I2F_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(int_value), "input beat dropped")

endmodule

bind int32_to_float32_convert_core i2f_checker u_i2f_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .int_value  (int_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .float_bits (float_bits)
);

`default_nettype wire
